### design/rgbcv_pkg.sv
// Shared widths, class codes, register indexes and reset values of the RGB colour vote classifier.
`default_nettype none
package rgbcv_pkg;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned GAIN_W     = 12;
  localparam int unsigned CLASS_W    = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned WINDOW_W   = 8;
  localparam int unsigned NUM_CLASS  = 5;

  typedef enum logic [CLASS_W-1:0] {
    CLS_BLACK = 3'd0,
    CLS_WHITE = 3'd1,
    CLS_RED   = 3'd2,
    CLS_BLUE  = 3'd3,
    CLS_GREEN = 3'd4,
    CLS_NONE  = 3'd5
  } class_e;

  localparam logic [CFG_IDX_W-1:0] REG_RED_GAIN_HIGH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RED_GAIN_LOW  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE_GAIN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RED_KNEE      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DARK_LEVEL    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_LEVEL  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 3'd6;

  localparam logic [GAIN_W-1:0]   RST_RED_GAIN_HIGH = 12'd1178;
  localparam logic [GAIN_W-1:0]   RST_RED_GAIN_LOW  = 12'd1126;
  localparam logic [GAIN_W-1:0]   RST_BLUE_GAIN     = 12'd870;
  localparam logic [SAMPLE_W-1:0] RST_RED_KNEE      = 16'd1200;
  localparam logic [SAMPLE_W-1:0] RST_DARK_LEVEL    = 16'd675;
  localparam logic [SAMPLE_W-1:0] RST_BRIGHT_LEVEL  = 16'd1400;
  localparam logic [WINDOW_W-1:0] RST_WINDOW_LENGTH = 8'd25;

endpackage
`default_nettype wire

### design/rgbcv_smp_if.sv
// Input channel: one raw red, green and blue sensor sample per item.
`default_nettype none
interface rgbcv_smp_if;
  import rgbcv_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] red_sample;
  logic [SAMPLE_W-1:0] green_sample;
  logic [SAMPLE_W-1:0] blue_sample;

  modport source (output valid, output red_sample, output green_sample,
                  output blue_sample, input ready);
  modport sink   (input valid, input red_sample, input green_sample,
                  input blue_sample, output ready);
endinterface
`default_nettype wire

### design/rgbcv_res_if.sv
// Result channel: the class of one sample and the window decision.
`default_nettype none
interface rgbcv_res_if;
  import rgbcv_pkg::*;

  logic               valid;
  logic               ready;
  logic [CLASS_W-1:0] sample_class;
  logic               window_done;
  logic [CLASS_W-1:0] majority_colour;

  modport source (output valid, output sample_class, output window_done,
                  output majority_colour, input ready);
  modport sink   (input valid, input sample_class, input window_done,
                  input majority_colour, output ready);
endinterface
`default_nettype wire

### design/rgb_colour_vote_classifier_top.sv
// Top level of the RGB colour vote classifier: scaling, classification and voting.
//
// smp_i takes one raw red/green/blue sample per item; res_o gives exactly one
// result item per sample: its class, a window-done flag and, on the sample
// that closes the window, the majority colour (zero otherwise).
// The configuration port writes register cfg_idx_i with cfg_data_i at any edge
// where cfg_we_i is high; write it only while the block is idle.
// A sample goes from the input register through the gain multipliers to the
// classify-and-vote result register before its result is valid.
// Throughput: one item per cycle while res_o.ready is high, set by the three-stage
// pipeline with one 16x12 multiplier per scaled channel in the middle stage.
// Reset loads the register defaults, clears the class counters and the
// sample count, and empties the pipeline.
// When the receiver stalls, the result register holds its item and the
// earlier stages keep accepting until they are full; smp_i.ready then drops.
`default_nettype none
module rgb_colour_vote_classifier_top #(
  parameter int unsigned COUNT_WIDTH = 8
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire [rgbcv_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire [rgbcv_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  rgbcv_smp_if.sink                        smp_i,
  rgbcv_res_if.source                      res_o
);
  import rgbcv_pkg::*;

  localparam int unsigned SUM_W  = SAMPLE_W + 2;
  localparam int unsigned PROD_W = SAMPLE_W + GAIN_W;

  // Configuration registers.
  logic [GAIN_W-1:0]   red_gain_high_q, red_gain_low_q, blue_gain_q;
  logic [SAMPLE_W-1:0] red_knee_q, dark_level_q, bright_level_q;
  logic [WINDOW_W-1:0] window_length_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_gain_high_q <= RST_RED_GAIN_HIGH;
      red_gain_low_q  <= RST_RED_GAIN_LOW;
      blue_gain_q     <= RST_BLUE_GAIN;
      red_knee_q      <= RST_RED_KNEE;
      dark_level_q    <= RST_DARK_LEVEL;
      bright_level_q  <= RST_BRIGHT_LEVEL;
      window_length_q <= RST_WINDOW_LENGTH;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_RED_GAIN_HIGH: red_gain_high_q <= cfg_data_i[GAIN_W-1:0];
        REG_RED_GAIN_LOW:  red_gain_low_q  <= cfg_data_i[GAIN_W-1:0];
        REG_BLUE_GAIN:     blue_gain_q     <= cfg_data_i[GAIN_W-1:0];
        REG_RED_KNEE:      red_knee_q      <= cfg_data_i;
        REG_DARK_LEVEL:    dark_level_q    <= cfg_data_i;
        REG_BRIGHT_LEVEL:  bright_level_q  <= cfg_data_i;
        REG_WINDOW_LENGTH: window_length_q <= cfg_data_i[WINDOW_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow control: a stage loads when it is empty or its item moves on.
  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;

  assign en3 = !v3_q || res_o.ready;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign smp_i.ready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= smp_i.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  // Stage 1: raw sample register.
  logic [SAMPLE_W-1:0] raw_r_q, raw_g_q, raw_b_q;

  always_ff @(posedge clk_i) begin
    if (en1 && smp_i.valid) begin
      raw_r_q <= smp_i.red_sample;
      raw_g_q <= smp_i.green_sample;
      raw_b_q <= smp_i.blue_sample;
    end
  end

  // Stage 2: Q2.10 scaling with saturation at full scale.
  function automatic logic [SAMPLE_W-1:0] scale_sat(input logic [SAMPLE_W-1:0] raw,
                                                    input logic [GAIN_W-1:0] gain);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(raw) * PROD_W'(gain);
    if (prod[PROD_W-1:SAMPLE_W+10] != '0) return '1;
    return prod[SAMPLE_W+9:10];
  endfunction

  logic [GAIN_W-1:0]   red_gain;
  logic [SAMPLE_W-1:0] scl_r_d, scl_b_d;
  logic [SAMPLE_W-1:0] scl_r_q, scl_g_q, scl_b_q;

  assign red_gain = (raw_r_q > red_knee_q) ? red_gain_high_q : red_gain_low_q;
  assign scl_r_d  = scale_sat(raw_r_q, red_gain);
  assign scl_b_d  = scale_sat(raw_b_q, blue_gain_q);

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      scl_r_q <= scl_r_d;
      scl_g_q <= raw_g_q;
      scl_b_q <= scl_b_d;
    end
  end

  // Stage 3: classify, count and vote.
  // floor(sum / 3) < dark is the same test as sum < 3 * dark.
  logic [SUM_W-1:0] sum3, dark3;
  class_e           cls_d;

  assign sum3  = SUM_W'(scl_r_q) + SUM_W'(scl_g_q) + SUM_W'(scl_b_q);
  assign dark3 = {1'b0, dark_level_q, 1'b0} + SUM_W'(dark_level_q);

  always_comb begin
    if (sum3 < dark3) begin
      cls_d = CLS_BLACK;
    end else if (scl_r_q > bright_level_q && scl_g_q > bright_level_q &&
                 scl_b_q > bright_level_q) begin
      cls_d = CLS_WHITE;
    end else if (scl_r_q > scl_g_q && scl_r_q > scl_b_q) begin
      cls_d = CLS_RED;
    end else if (scl_b_q > scl_g_q && scl_b_q > scl_r_q) begin
      cls_d = CLS_BLUE;
    end else if (scl_g_q > scl_r_q && scl_g_q > scl_b_q) begin
      cls_d = CLS_GREEN;
    end else begin
      cls_d = CLS_NONE;
    end
  end

  logic [NUM_CLASS-1:0][COUNT_WIDTH-1:0] cnt_q, cnt_inc, cnt_d;
  logic [WINDOW_W-1:0]                   seen_q, seen_d;
  logic [WINDOW_W:0]                     seen_inc, win_len;
  logic                                  done_d;
  class_e                                maj_d;
  logic                                  step;

  assign step = v2_q && en3;

  // The closing sample is counted before the majority is taken.
  always_comb begin
    for (int c = 0; c < NUM_CLASS; c++) begin
      cnt_inc[c] = cnt_q[c];
      if (CLASS_W'(c) == cls_d && cnt_q[c] != '1) begin
        cnt_inc[c] = cnt_q[c] + COUNT_WIDTH'(1);
      end
    end
  end

  assign win_len  = (window_length_q == '0) ? (WINDOW_W+1)'(1) : {1'b0, window_length_q};
  assign seen_inc = {1'b0, seen_q} + (WINDOW_W+1)'(1);
  assign done_d   = seen_inc >= win_len;
  assign seen_d   = done_d ? '0 : seen_inc[WINDOW_W-1:0];
  assign cnt_d    = done_d ? '0 : cnt_inc;

  always_comb begin
    if (cnt_inc[0] > cnt_inc[1] && cnt_inc[0] > cnt_inc[2] &&
        cnt_inc[0] > cnt_inc[3] && cnt_inc[0] > cnt_inc[4]) begin
      maj_d = CLS_BLACK;
    end else if (cnt_inc[1] > cnt_inc[2] && cnt_inc[1] > cnt_inc[3] &&
                 cnt_inc[1] > cnt_inc[4]) begin
      maj_d = CLS_WHITE;
    end else if (cnt_inc[2] > cnt_inc[3] && cnt_inc[2] > cnt_inc[4]) begin
      maj_d = CLS_RED;
    end else if (cnt_inc[3] > cnt_inc[4]) begin
      maj_d = CLS_BLUE;
    end else begin
      maj_d = CLS_GREEN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      seen_q <= '0;
    end else if (step) begin
      cnt_q  <= cnt_d;
      seen_q <= seen_d;
    end
  end

  class_e res_cls_q, res_maj_q;
  logic   res_done_q;

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_cls_q  <= cls_d;
      res_done_q <= done_d;
      res_maj_q  <= done_d ? maj_d : CLS_BLACK;
    end
  end

  assign res_o.valid           = v3_q;
  assign res_o.sample_class    = res_cls_q;
  assign res_o.window_done     = res_done_q;
  assign res_o.majority_colour = res_maj_q;

`ifndef SYNTH
  a_window_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && done_d) |=> (seen_q == '0 && cnt_q == '0))
    else $error("counters not cleared after the closing item");

  a_tie_not_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && !done_d && cls_d == CLS_NONE) |=> $stable(cnt_q))
    else $error("unclassified item changed a class counter");

  a_maj_zero_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && !res_done_q) |-> (res_maj_q == CLS_BLACK))
    else $error("majority colour set on an item that does not close the window");

  a_ready_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !smp_i.ready |-> (v1_q && v2_q && v3_q && !res_o.ready))
    else $error("input stalled while the pipeline has room");

  a_seen_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step |=> $stable(seen_q))
    else $error("sample count changed without an item");
`endif

endmodule
`default_nettype wire

### sim/testbench.sv
// Self-checking testbench for the RGB colour vote classifier: random and directed samples.
`timescale 1ns / 100ps
module testbench;
  import rgbcv_pkg::*;

  localparam int unsigned COUNT_W = 8;
  localparam int unsigned HOLD_CYCLES = 300;

  typedef struct {
    logic [CLASS_W-1:0] cls;
    logic               done;
    logic [CLASS_W-1:0] maj;
  } vote_result_t;

  // Tracks the classifier's registers and vote counters and holds the
  // results still owed by the block.
  class vote_scoreboard;
    logic [GAIN_W-1:0]   red_gain_hi  = RST_RED_GAIN_HIGH;
    logic [GAIN_W-1:0]   red_gain_lo  = RST_RED_GAIN_LOW;
    logic [GAIN_W-1:0]   blue_gain    = RST_BLUE_GAIN;
    logic [SAMPLE_W-1:0] red_knee     = RST_RED_KNEE;
    logic [SAMPLE_W-1:0] dark_lvl     = RST_DARK_LEVEL;
    logic [SAMPLE_W-1:0] bright_lvl   = RST_BRIGHT_LEVEL;
    logic [WINDOW_W-1:0] window_len   = RST_WINDOW_LENGTH;
    logic [COUNT_W-1:0]  votes [NUM_CLASS];
    logic [WINDOW_W-1:0] seen = '0;
    vote_result_t        owed [$];
    int                  failures = 0;

    function new();
      foreach (votes[i]) votes[i] = '0;
    endfunction

    function logic [SAMPLE_W-1:0] scale(logic [SAMPLE_W-1:0] raw, logic [GAIN_W-1:0] gain);
      logic [27:0] prod;
      prod = 28'(raw) * 28'(gain);
      if (prod[27:10] > 18'd65535) return 16'hFFFF;
      return prod[25:10];
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_RED_GAIN_HIGH: red_gain_hi = val[GAIN_W-1:0];
        REG_RED_GAIN_LOW:  red_gain_lo = val[GAIN_W-1:0];
        REG_BLUE_GAIN:     blue_gain   = val[GAIN_W-1:0];
        REG_RED_KNEE:      red_knee    = val;
        REG_DARK_LEVEL:    dark_lvl    = val;
        REG_BRIGHT_LEVEL:  bright_lvl  = val;
        REG_WINDOW_LENGTH: window_len  = val[WINDOW_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_sample(logic [SAMPLE_W-1:0] r, logic [SAMPLE_W-1:0] g,
                              logic [SAMPLE_W-1:0] b);
      logic [SAMPLE_W-1:0] rs, bs, mean;
      logic [17:0]         sum;
      logic [8:0]          len;
      class_e              cls, maj;
      vote_result_t        res;
      rs = scale(r, (r > red_knee) ? red_gain_hi : red_gain_lo);
      bs = scale(b, blue_gain);
      sum = 18'(rs) + 18'(g) + 18'(bs);
      mean = 16'(sum / 18'd3);
      if (mean < dark_lvl) cls = CLS_BLACK;
      else if (rs > bright_lvl && g > bright_lvl && bs > bright_lvl) cls = CLS_WHITE;
      else if (rs > g && rs > bs) cls = CLS_RED;
      else if (bs > g && bs > rs) cls = CLS_BLUE;
      else if (g > rs && g > bs) cls = CLS_GREEN;
      else cls = CLS_NONE;
      if (cls != CLS_NONE && votes[cls] != {COUNT_W{1'b1}}) votes[cls]++;
      len = (window_len == '0) ? 9'd1 : {1'b0, window_len};
      maj = CLS_BLACK;
      res.done = ({1'b0, seen} + 9'd1 >= len);
      if (res.done) begin
        if (votes[CLS_BLACK] > votes[CLS_WHITE] && votes[CLS_BLACK] > votes[CLS_RED] &&
            votes[CLS_BLACK] > votes[CLS_BLUE] && votes[CLS_BLACK] > votes[CLS_GREEN])
          maj = CLS_BLACK;
        else if (votes[CLS_WHITE] > votes[CLS_RED] && votes[CLS_WHITE] > votes[CLS_BLUE] &&
                 votes[CLS_WHITE] > votes[CLS_GREEN])
          maj = CLS_WHITE;
        else if (votes[CLS_RED] > votes[CLS_BLUE] && votes[CLS_RED] > votes[CLS_GREEN])
          maj = CLS_RED;
        else if (votes[CLS_BLUE] > votes[CLS_GREEN])
          maj = CLS_BLUE;
        else
          maj = CLS_GREEN;
        foreach (votes[i]) votes[i] = '0;
        seen = '0;
      end else begin
        seen = seen + 8'd1;
      end
      res.cls = cls;
      res.maj = maj;
      owed.push_back(res);
    endfunction

    function void flag(string msg);
      failures++;
      if (failures <= 10) $display("%s", msg);
    endfunction

    function void check_result(logic [CLASS_W-1:0] cls, logic done, logic [CLASS_W-1:0] maj);
      vote_result_t exp;
      if (owed.size() == 0) begin
        flag($sformatf("unexpected result: class %0d done %0d majority %0d", cls, done, maj));
        return;
      end
      exp = owed.pop_front();
      if (cls !== exp.cls || done !== exp.done || maj !== exp.maj)
        flag($sformatf("result mismatch: expected class %0d done %0d majority %0d, got %0d %0d %0d",
                       exp.cls, exp.done, exp.maj, cls, done, maj));
    endfunction

    function int pending();
      return owed.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    sent = 0;
  int                    results_seen = 0;
  vote_scoreboard        sb;

  rgbcv_smp_if smp ();
  rgbcv_res_if res ();

  rgb_colour_vote_classifier_top #(
    .COUNT_WIDTH (COUNT_W)
  ) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .smp_i      (smp),
    .res_o      (res)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("rgb_colour_vote_classifier_top verification failed");
    $finish;
  end

  // Result side: random back-pressure, one long hold-off that fills the pipeline, a stall-free stretch.
  initial begin
    int  hold_left;
    bit  held;
    hold_left = 0;
    held = 1'b0;
    res.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && results_seen >= 150) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res.ready <= 1'b0;
      end else if (results_seen >= 600 && results_seen < 900) begin
        res.ready <= 1'b1;
      end else begin
        res.ready <= ($urandom_range(99) >= 6);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && res.valid && res.ready) begin
      sb.check_result(res.sample_class, res.window_done, res.majority_colour);
      results_seen++;
    end
  end

  task automatic send_sample(input logic [SAMPLE_W-1:0] r, input logic [SAMPLE_W-1:0] g,
                             input logic [SAMPLE_W-1:0] b);
    while (!(sent >= 600 && sent < 900) && $urandom_range(99) < 6) begin
      @(negedge clk);
      smp.valid <= 1'b0;
    end
    @(negedge clk);
    smp.valid        <= 1'b1;
    smp.red_sample   <= r;
    smp.green_sample <= g;
    smp.blue_sample  <= b;
    do @(posedge clk); while (!smp.ready);
    sb.note_sample(r, g, b);
    sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    smp.valid <= 1'b0;
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_data  <= val;
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_config(input int gh, input int gl, input int bg, input int knee,
                            input int dark, input int bright, input int wl);
    write_reg(REG_RED_GAIN_HIGH, 16'(gh));
    write_reg(REG_RED_GAIN_LOW, 16'(gl));
    write_reg(REG_BLUE_GAIN, 16'(bg));
    write_reg(REG_RED_KNEE, 16'(knee));
    write_reg(REG_DARK_LEVEL, 16'(dark));
    write_reg(REG_BRIGHT_LEVEL, 16'(bright));
    write_reg(REG_WINDOW_LENGTH, 16'(wl));
  endtask

  // Waits until every owed result has come back, then lets the pipeline settle.
  task automatic wait_idle();
    @(negedge clk);
    smp.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Each window leans toward one kind of sample so that majorities vary.
  task automatic run_phase(input int n);
    int                  wl, dom, kind;
    logic [SAMPLE_W-1:0] r, g, b;
    wl = (sb.window_len == '0) ? 1 : int'(sb.window_len);
    dom = 0;
    for (int i = 0; i < n; i++) begin
      if (i % wl == 0) dom = $urandom_range(0, 6);
      kind = ($urandom_range(99) < 70) ? dom : $urandom_range(0, 6);
      case (kind)
        0: begin
          r = 16'($urandom_range(0, sb.dark_lvl));
          g = 16'($urandom_range(0, sb.dark_lvl));
          b = 16'($urandom_range(0, sb.dark_lvl));
        end
        1: begin
          r = 16'($urandom_range(sb.bright_lvl, 65535));
          g = 16'($urandom_range(sb.bright_lvl, 65535));
          b = 16'($urandom_range(sb.bright_lvl, 65535));
        end
        2: begin
          r = 16'($urandom_range(2000, 65535));
          g = 16'($urandom_range(0, r / 2));
          b = 16'($urandom_range(0, r / 2));
        end
        3: begin
          b = 16'($urandom_range(2000, 65535));
          r = 16'($urandom_range(0, b / 2));
          g = 16'($urandom_range(0, b / 2));
        end
        4: begin
          g = 16'($urandom_range(2000, 65535));
          r = 16'($urandom_range(0, g / 2));
          b = 16'($urandom_range(0, g / 2));
        end
        5: begin
          // Green equal to scaled red can give a tie for the largest channel.
          r = 16'($urandom_range(0, 65535));
          g = sb.scale(r, (r > sb.red_knee) ? sb.red_gain_hi : sb.red_gain_lo);
          b = 16'($urandom_range(0, g));
        end
        default: begin
          r = 16'($urandom());
          g = 16'($urandom());
          b = 16'($urandom());
        end
      endcase
      send_sample(r, g, b);
    end
  endtask

  initial begin
    int gh, gl, bg, knee, dark, bright, wl, pick;
    sb = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    smp.valid = 1'b0;
    smp.red_sample = '0;
    smp.green_sample = '0;
    smp.blue_sample = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset settings: extremes, saturation, knee and dark boundaries, a tie.
    send_sample(16'h0000, 16'h0000, 16'h0000);
    send_sample(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_sample(16'hFFFF, 16'h0000, 16'h0000);
    send_sample(16'h0000, 16'h0000, 16'hFFFF);
    send_sample(16'h0000, 16'hFFFF, 16'h0000);
    send_sample(16'd1200, 16'd700, 16'd700);
    send_sample(16'd1201, 16'd700, 16'd700);
    send_sample(16'd2000, 16'd2300, 16'd100);
    send_sample(16'd0, 16'd2024, 16'd0);
    send_sample(16'd0, 16'd2025, 16'd0);
    send_sample(16'hAAAA, 16'h5555, 16'hAAAA);
    send_sample(16'h5555, 16'hAAAA, 16'h5555);
    wait_idle();

    // Unity gains with a one-sample window; this also cuts the open window short.
    set_config(1024, 1024, 1024, 1200, 675, 1400, 1);
    send_sample(16'd1401, 16'd1401, 16'd1401);
    send_sample(16'd1400, 16'd1401, 16'd1401);
    send_sample(16'd1401, 16'd1400, 16'd1400);
    send_sample(16'd3000, 16'd3000, 16'd3000);
    wait_idle();

    // Three-sample windows: a three-way split goes to green, black beats white.
    write_reg(REG_WINDOW_LENGTH, 16'd3);
    send_sample(16'd5000, 16'd1000, 16'd1000);
    send_sample(16'd1000, 16'd1000, 16'd5000);
    send_sample(16'd1000, 16'd5000, 16'd1000);
    send_sample(16'd0, 16'd0, 16'd0);
    send_sample(16'd0, 16'd0, 16'd0);
    send_sample(16'd2000, 16'd2000, 16'd2000);
    wait_idle();

    set_config(int'(RST_RED_GAIN_HIGH), int'(RST_RED_GAIN_LOW), int'(RST_BLUE_GAIN),
               int'(RST_RED_KNEE), int'(RST_DARK_LEVEL), int'(RST_BRIGHT_LEVEL),
               int'(RST_WINDOW_LENGTH));
    run_phase(200);
    wait_idle();

    // Largest gains, zero knee and levels: every sample with no zero channel is white.
    set_config(4095, 4095, 4095, 0, 0, 0, 255);
    run_phase(300);
    wait_idle();

    // Zero gains and a zero window length: every sample closes a window.
    set_config(0, 0, 0, 65535, 65535, 65535, 0);
    run_phase(40);
    wait_idle();

    set_config(1024, 1126, 870, 1200, 675, 1400, 200);
    run_phase(60);
    wait_idle();
    write_reg(REG_WINDOW_LENGTH, 16'd10);
    run_phase(30);
    wait_idle();

    while (sent < 1420) begin
      gh = ($urandom_range(9) == 0) ? $urandom_range(0, 4095) : $urandom_range(800, 1400);
      gl = ($urandom_range(9) == 0) ? $urandom_range(0, 4095) : $urandom_range(800, 1400);
      bg = ($urandom_range(9) == 0) ? $urandom_range(0, 4095) : $urandom_range(600, 1400);
      knee = ($urandom_range(1) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 4000);
      dark = $urandom_range(0, 3000);
      bright = ($urandom_range(9) == 0) ? 65535 : $urandom_range(0, 30000);
      pick = $urandom_range(0, 19);
      wl = (pick == 0) ? 0 : (pick == 1) ? 255 : $urandom_range(1, 40);
      set_config(gh, gl, bg, knee, dark, bright, wl);
      run_phase($urandom_range(40, 120));
      wait_idle();
    end

    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("rgb_colour_vote_classifier_top verification clean");
    end else begin
      $display("rgb_colour_vote_classifier_top verification failed");
    end
    $finish;
  end

endmodule
